@@ hw/rtl/cts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants for the token scanner
// Token kinds, scan modes, class flags and character helpers.
// ----------------------------------------------------------------------------
package cts_pkg;

  typedef enum logic [6:0] {
    MODE_IDLE       = 7'b0000001,
    MODE_WORD       = 7'b0000010,
    MODE_STR        = 7'b0000100,
    MODE_STR_ESC    = 7'b0001000,
    MODE_BLOCK      = 7'b0010000,
    MODE_BLOCK_STAR = 7'b0100000,
    MODE_LINE       = 7'b1000000
  } mode_t;

  localparam logic [5:0] K_INTLIT   = 6'd13;
  localparam logic [5:0] K_FLOATLIT = 6'd14;
  localparam logic [5:0] K_STRLIT   = 6'd15;
  localparam logic [5:0] K_IDENT    = 6'd16;
  localparam logic [5:0] K_ERROR    = 6'd17;
  localparam logic [5:0] K_NONE     = 6'd63;

  localparam int unsigned F_NUM   = 0;
  localparam int unsigned F_DOT1  = 1;
  localparam int unsigned F_DOT2  = 2;
  localparam int unsigned F_IDENT = 3;

  localparam logic [11:0] LEN_LIMIT = 12'd4095;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line_number;
    logic [11:0] start_column;
    logic [11:0] token_length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } char_item_t;

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h2C: k = 6'd18;  8'h3B: k = 6'd19;  8'h28: k = 6'd20;
      8'h29: k = 6'd21;  8'h5B: k = 6'd22;  8'h5D: k = 6'd23;
      8'h7B: k = 6'd24;  8'h7D: k = 6'd25;  8'h2B: k = 6'd26;
      8'h2D: k = 6'd27;  8'h2A: k = 6'd28;  8'h2F: k = 6'd29;
      8'h3E: k = 6'd30;  8'h3C: k = 6'd31;  8'h3D: k = 6'd32;
      8'h7C: k = 6'd33;  8'h26: k = 6'd34;  8'h25: k = 6'd35;
      8'h21: k = 6'd36;  8'h3F: k = 6'd37;  8'h3A: k = 6'd38;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic pairable(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h3E ||
           c == 8'h3C || c == 8'h3D || c == 8'h7C || c == 8'h26 || c == 8'h25 ||
           c == 8'h21;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = K_NONE;
    if (b == 8'h3D) begin
      case (a)
        8'h2B: k = 6'd39;  8'h2D: k = 6'd41;  8'h2A: k = 6'd43;
        8'h2F: k = 6'd44;  8'h3E: k = 6'd45;  8'h3C: k = 6'd46;
        8'h3D: k = 6'd47;  8'h25: k = 6'd50;  8'h21: k = 6'd51;
        default: k = K_NONE;
      endcase
    end else if (a == b) begin
      case (a)
        8'h2B: k = 6'd40;  8'h2D: k = 6'd42;
        8'h7C: k = 6'd48;  8'h26: k = 6'd49;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  // Keyword texts, first byte in the low lane.
  localparam int unsigned KW_COUNT = 13;
  typedef logic [7:0][7:0] kw_text_t;
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0000_6669,   // if
    64'h0000_0000_6573_6C65,   // else
    64'h0000_0065_6C69_6877,   // while
    64'h0000_006C_6974_6E75,   // until
    64'h0000_0000_0072_6F66,   // for
    64'h0000_0000_0074_6E69,   // int
    64'h0000_0074_616F_6C66,   // float
    64'h0000_6E72_7574_6572,   // return
    64'h006E_6165_6C6F_6F62,   // boolean
    64'h0000_0000_7261_6863,   // char
    64'h0000_676E_6972_7473,   // string
    64'h0000_0000_6575_7274,   // true
    64'h0000_0065_736C_6166    // false
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4, 4'd6, 4'd4, 4'd5
  };

endpackage
`default_nettype wire

@@ hw/rtl/cts_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_stream_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface cts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/cts_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_classify: word kind decode
// Matches the stored prefix against the keywords, else uses class flags.
// ----------------------------------------------------------------------------
module cts_classify #(
  parameter int unsigned KEYWORD_CHARS = 8
) (
  input  wire logic [KEYWORD_CHARS-1:0][7:0] prefix,
  input  wire logic [11:0]                   word_length,
  input  wire logic [3:0]                    flags,
  output logic      [5:0]                    kind
);
  import cts_pkg::*;

  always_comb begin
    logic found;
    logic match;
    found = 1'b0;
    kind  = K_ERROR;
    for (int k = 0; k < KW_COUNT; k++) begin
      match = !found && (word_length == 12'(KW_LEN[k]));
      for (int b = 0; b < 8; b++) begin
        if (b < KW_LEN[k]) begin
          if (b >= KEYWORD_CHARS) match = 1'b0;
          else if (prefix[b] != KW_TEXT[k][b]) match = 1'b0;
        end
      end
      if (match) begin
        found = 1'b1;
        kind  = 6'(k);
      end
    end
    if (!found) begin
      if (flags[F_NUM] && !flags[F_DOT1]) kind = K_INTLIT;
      else if (flags[F_NUM] && !flags[F_DOT2]) kind = K_FLOATLIT;
      else if (flags[F_IDENT]) kind = K_IDENT;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cts_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_out_queue: result buffer
// Four-entry queue of tokens; absorbs up to two tokens per cycle.
// ----------------------------------------------------------------------------
module cts_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_count,
  input  wire cts_pkg::token_t   push0,
  input  wire cts_pkg::token_t   push1,
  output logic                   room_two,
  cts_stream_if.source           out_ch
);
  import cts_pkg::*;

  token_t     mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = count != 3'd0;
  assign out_ch.data  = mem[rd_ptr];
  assign room_two     = (count + 3'(push_count)) <= 3'd2;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr_ptr] <= push0;
    if (push_count == 2'd2) mem[wr_ptr + 2'd1] <= push1;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(push_count) - 3'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cts_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_scan: scanner state update
// Applies one registered character to the scan state, makes up to two tokens.
// ----------------------------------------------------------------------------
module cts_scan #(
  parameter int unsigned MAX_COLUMNS   = 4096,
  parameter int unsigned KEYWORD_CHARS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire cts_pkg::char_item_t  item,
  output logic [1:0]                push_count,
  output cts_pkg::token_t           push0,
  output cts_pkg::token_t           push1
);
  import cts_pkg::*;

  localparam logic [11:0] COL_LIMIT = (MAX_COLUMNS - 1 > 4095) ? 12'd4095
                                                               : 12'(MAX_COLUMNS - 1);
  localparam int unsigned PW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

  mode_t       mode, mode_next;
  logic [7:0]  pend, pend_next;
  logic [KEYWORD_CHARS-1:0][7:0] prefix, prefix_next;
  logic [11:0] wlen, wlen_next;
  logic [11:0] wstart, wstart_next;
  logic [3:0]  flags, flags_next;
  logic [11:0] column;
  logic [15:0] line;
  logic [5:0]  word_kind;

  cts_classify #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_classify (
    .prefix     (prefix),
    .word_length(wlen),
    .flags      (flags),
    .kind       (word_kind)
  );

  always_comb begin
    logic [7:0]  c;
    logic [5:0]  sk;
    logic [5:0]  pk;
    logic [1:0]  n;
    logic [5:0]  kinds [2];
    logic [11:0] starts [2];
    logic [11:0] lens [2];
    logic        plain;
    logic        in_word;
    c  = item.ch;
    n  = 2'd0;
    kinds  = '{K_NONE, K_NONE};
    starts = '{12'd0, 12'd0};
    lens   = '{12'd0, 12'd0};
    mode_next   = mode;
    pend_next   = pend;
    prefix_next = prefix;
    wlen_next   = wlen;
    wstart_next = wstart;
    flags_next  = flags;
    plain       = 1'b0;
    in_word     = mode == MODE_WORD;
    sk = single_kind(c);
    pk = pair_kind(pend, c);
    if (item.line_end) begin
      if (pend != 8'd0) begin
        kinds[n[0]] = single_kind(pend) == K_NONE ? 6'd0 : single_kind(pend);
        starts[n[0]] = wstart; lens[n[0]] = 12'd1; n = n + 2'd1;
        pend_next = 8'd0;
      end
      case (mode)
        MODE_WORD: begin
          kinds[n[0]] = word_kind; starts[n[0]] = wstart; lens[n[0]] = wlen;
          n = n + 2'd1;
          mode_next = MODE_IDLE;
        end
        MODE_STR, MODE_STR_ESC: begin
          kinds[n[0]] = K_ERROR; starts[n[0]] = wstart; lens[n[0]] = wlen;
          n = n + 2'd1;
          mode_next = MODE_IDLE;
        end
        MODE_LINE:       mode_next = MODE_IDLE;
        MODE_BLOCK_STAR: mode_next = MODE_BLOCK;
        default:         mode_next = mode;
      endcase
    end else begin
      case (mode)
        MODE_LINE: mode_next = mode;
        MODE_BLOCK: if (c == 8'h2A) mode_next = MODE_BLOCK_STAR;
        MODE_BLOCK_STAR: begin
          if (c == 8'h2F) mode_next = MODE_IDLE;
          else if (c != 8'h2A) mode_next = MODE_BLOCK;
        end
        MODE_STR: begin
          if (wlen < LEN_LIMIT) wlen_next = wlen + 12'd1;
          if (c == 8'h5C) mode_next = MODE_STR_ESC;
          else if (c == 8'h22) begin
            kinds[0] = K_STRLIT; starts[0] = wstart; lens[0] = wlen_next; n = 2'd1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_STR_ESC: begin
          if (wlen < LEN_LIMIT) wlen_next = wlen + 12'd1;
          mode_next = MODE_STR;
        end
        default: begin
          plain = 1'b1;
          if (pend != 8'd0) begin
            pend_next = 8'd0;
            if (pend == 8'h2F && c == 8'h2F) begin
              mode_next = MODE_LINE; plain = 1'b0;
            end else if (pend == 8'h2F && c == 8'h2A) begin
              mode_next = MODE_BLOCK; plain = 1'b0;
            end else if (pk != K_NONE) begin
              kinds[0] = pk; starts[0] = wstart; lens[0] = 12'd2; n = 2'd1;
              plain = 1'b0;
            end else begin
              kinds[0] = single_kind(pend) == K_NONE ? 6'd0 : single_kind(pend);
              starts[0] = wstart; lens[0] = 12'd1; n = 2'd1;
            end
          end
        end
      endcase
      if (plain) begin
        if (!is_space(c) && c != 8'h22 && sk == K_NONE) begin
          if (!in_word) begin
            mode_next   = MODE_WORD;
            wstart_next = column;
            wlen_next   = 12'd0;
            flags_next  = 4'b1001;
          end else begin
            wlen_next = wlen;
          end
          if (wlen_next < 12'(KEYWORD_CHARS)) prefix_next[PW'(wlen_next)] = c;
          if (is_digit(c)) begin
            if (wlen_next == 12'd0) flags_next[F_IDENT] = 1'b0;
          end else if (c == 8'h2E) begin
            flags_next[F_IDENT] = 1'b0;
            if (flags_next[F_DOT1]) flags_next[F_DOT2] = 1'b1;
            else flags_next[F_DOT1] = 1'b1;
          end else begin
            flags_next[F_NUM] = 1'b0;
            if (!(is_alpha(c) || (c == 8'h5F && wlen_next != 12'd0)))
              flags_next[F_IDENT] = 1'b0;
          end
          if (wlen_next < LEN_LIMIT) wlen_next = wlen_next + 12'd1;
        end else begin
          if (in_word) begin
            kinds[n[0]] = word_kind; starts[n[0]] = wstart; lens[n[0]] = wlen;
            n = n + 2'd1;
            mode_next = MODE_IDLE;
          end
          if (!is_space(c)) begin
            if (c == 8'h22) begin
              mode_next = MODE_STR; wstart_next = column; wlen_next = 12'd1;
            end else if (pairable(c)) begin
              pend_next = c; wstart_next = column;
            end else begin
              kinds[n[0]] = sk; starts[n[0]] = column; lens[n[0]] = 12'd1;
              n = n + 2'd1;
            end
          end
        end
      end
    end
    push_count = step ? n : 2'd0;
    push0.kind = kinds[0]; push0.line_number = line;
    push0.start_column = starts[0]; push0.token_length = lens[0];
    push0.last = n == 2'd1;
    push1.kind = kinds[1]; push1.line_number = line;
    push1.start_column = starts[1]; push1.token_length = lens[1];
    push1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (step) prefix <= prefix_next;
    if (rst) begin
      mode   <= MODE_IDLE;
      pend   <= '0;
      wlen   <= '0;
      wstart <= '0;
      flags  <= '0;
      column <= '0;
      line   <= 16'd1;
    end else if (step) begin
      mode   <= mode_next;
      pend   <= pend_next;
      wlen   <= wlen_next;
      wstart <= wstart_next;
      flags  <= flags_next;
      if (item.line_end) begin
        column <= '0;
        if (line != 16'hFFFF) line <= line + 16'd1;
      end else if (column < COL_LIMIT) begin
        column <= column + 12'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/c_like_token_scanner_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_like_token_scanner_top: streaming tokenizer for a C-like language
// Turns a character stream into kind/line/column/length tokens.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one source byte or a line-end marker per transfer.
//   out_ch carries tokens; the final token caused by one input has last set.
//   An input transfer lands in an input register; the next cycle the scan
//   logic updates the state and writes zero, one or two tokens into a
//   four-entry result queue. The first token can transfer once it has been
//   written into the queue.
//   Throughput: one character per cycle while input ready is high. Input
//   ready stays high while the queue has room for two tokens beyond the one
//   in flight; a stalled receiver fills the queue and then holds off input,
//   nothing is dropped.
//   Reset (rst, synchronous) returns to idle, line 1, column 0, and empties
//   the queue.
// ----------------------------------------------------------------------------
module c_like_token_scanner_top #(
  parameter int unsigned MAX_COLUMNS   = 4096,
  parameter int unsigned KEYWORD_CHARS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  cts_stream_if.sink   in_ch,
  cts_stream_if.source out_ch
);
  import cts_pkg::*;

  char_item_t item;
  logic       item_valid;
  logic [1:0] push_count;
  token_t     push0, push1;
  logic       room_two;
  logic       in_xfer;

  // Keep space for the token pair from the registered item plus a new one.
  assign in_ch.ready = room_two;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_xfer) item <= in_ch.data;
    if (rst) item_valid <= 1'b0;
    else     item_valid <= in_xfer;
  end

  cts_scan #(.MAX_COLUMNS(MAX_COLUMNS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (item_valid),
    .item      (item),
    .push_count(push_count),
    .push0     (push0),
    .push1     (push1)
  );

  cts_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push0     (push0),
    .push1     (push1),
    .room_two  (room_two),
    .out_ch    (out_ch)
  );

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> push_count == 2'd0) else $error("push without item");
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    push_count == 2'd1 |-> push0.last) else $error("single token lacks last");
  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> item_valid) else $error("item lost");

endmodule
`default_nettype wire
